// File: hw/rtl/gcsd_pkg.sv
// Package for the GPU command stream deframer: parse phase codes, command ids,
// field widths and the item and result structs shared among the modules.
// No dependencies.
`timescale 1ns / 1ps

package gcsd_pkg;

    localparam int OFFSET_BITS_DEFAULT = 20;

    localparam int WORD_W   = 32;
    localparam int CMD_W    = 20;
    localparam int IDX_W    = 11;
    localparam int TOTAL_W  = 12;
    localparam int OFS_W    = 20;
    localparam int ENTRY_W  = 9;
    localparam int LANE_W   = 2;
    localparam int M_DATA_W = 128;

    // Header layout.
    localparam int CNT_LO = 20;
    localparam int CNT_HI = 30;

    localparam logic [CMD_W-1:0] CMD_VERTLIST_MODE = 20'hF02C0;
    localparam logic [CMD_W-1:0] CMD_ENTRY_LIST    = 20'hF02C1;

    // Parse phases.
    localparam logic [1:0] PH_FIRST  = 2'd0;
    localparam logic [1:0] PH_HEADER = 2'd1;
    localparam logic [1:0] PH_PARAMS = 2'd2;
    localparam logic [1:0] PH_PAD    = 2'd3;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              buffer_start;
    } in_item_t;

    typedef struct packed {
        logic                entry_incomplete;
        logic [LANE_W-1:0]   entry_lane;
        logic [ENTRY_W-1:0]  entry_index;
        logic [WORD_W-1:0]   vertex_list_mode;
        logic [OFS_W-1:0]    command_offset;
        logic                last_param;
        logic [WORD_W-1:0]   param_value;
        logic [IDX_W-1:0]    param_index;
        logic [CMD_W-1:0]    command_id;
    } result_t;

endpackage

// File: hw/rtl/gcsd_in_stage.sv
// Input register of the deframer: captures one stream transfer and holds it
// until the parser can take it. Depends on gcsd_pkg.
`timescale 1ns / 1ps

module gcsd_in_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  gcsd_pkg::in_item_t s_item,
    input  logic               pipe_ready,
    output logic               fire,
    output gcsd_pkg::in_item_t item
);

    logic               valid_reg;
    logic               valid_next;
    gcsd_pkg::in_item_t item_reg;

    assign fire          = valid_reg && pipe_ready;
    assign s_axis_tready = !valid_reg || pipe_ready;
    assign item          = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_axis_tvalid && s_axis_tready) begin
            valid_next = 1'b1;
        end else if (fire) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            item_reg <= s_item;
        end
    end

endmodule

// File: hw/rtl/gcsd_parser.sv
// Parse state and result formation of the deframer: one word per fired cycle
// moves the phase and produces at most one result. Depends on gcsd_pkg.
`timescale 1ns / 1ps

module gcsd_parser #(
    parameter int OFFSET_BITS = gcsd_pkg::OFFSET_BITS_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               fire,
    input  gcsd_pkg::in_item_t item,
    output logic               res_valid,
    output gcsd_pkg::result_t  res
);

    logic [1:0]                     phase_reg,  phase_next;
    logic [gcsd_pkg::WORD_W-1:0]    held_reg,   held_next;
    logic [gcsd_pkg::CMD_W-1:0]     cmd_reg,    cmd_next;
    logic [gcsd_pkg::TOTAL_W-1:0]   total_reg,  total_next;
    logic [gcsd_pkg::IDX_W-1:0]     npi_reg,    npi_next;
    logic [OFFSET_BITS-1:0]         wc_reg,     wc_next;
    logic [OFFSET_BITS-1:0]         cs_reg,     cs_next;
    logic [gcsd_pkg::WORD_W-1:0]    mode_reg,   mode_next;

    logic [1:0]                     phase_cur;
    logic [OFFSET_BITS-1:0]         pos;
    logic [gcsd_pkg::IDX_W-1:0]     e_idx;
    logic [gcsd_pkg::IDX_W-1:0]     e_idx_top;
    logic [gcsd_pkg::WORD_W-1:0]    e_val;
    logic                           e_last;
    logic                           is_entry;
    logic [OFFSET_BITS+gcsd_pkg::OFS_W-1:0] cs_ext;

    // A buffer start restarts the parse on this very word.
    assign phase_cur = item.buffer_start ? gcsd_pkg::PH_FIRST : phase_reg;
    assign pos       = item.buffer_start ? '0 : wc_reg;

    always_comb begin
        phase_next = phase_reg;
        held_next  = held_reg;
        cmd_next   = cmd_reg;
        total_next = total_reg;
        npi_next   = npi_reg;
        cs_next    = cs_reg;
        mode_next  = mode_reg;
        wc_next    = wc_reg;
        res_valid  = 1'b0;
        e_idx      = npi_reg;
        e_val      = item.word;
        if (fire) begin
            wc_next = pos + 1'b1;
            case (phase_cur)
                gcsd_pkg::PH_FIRST: begin
                    held_next  = item.word;
                    cs_next    = pos;
                    phase_next = gcsd_pkg::PH_HEADER;
                end
                gcsd_pkg::PH_HEADER: begin
                    cmd_next   = item.word[gcsd_pkg::CMD_W-1:0];
                    total_next = {1'b0, item.word[gcsd_pkg::CNT_HI:gcsd_pkg::CNT_LO]}
                                 + 1'b1;
                    if (item.word[gcsd_pkg::CMD_W-1:0] == gcsd_pkg::CMD_VERTLIST_MODE) begin
                        mode_next = held_reg;
                    end
                    e_idx     = '0;
                    e_val     = held_reg;
                    res_valid = 1'b1;
                    npi_next  = {{(gcsd_pkg::IDX_W-1){1'b0}}, 1'b1};
                    if (item.word[gcsd_pkg::CNT_HI:gcsd_pkg::CNT_LO] == '0) begin
                        phase_next = gcsd_pkg::PH_FIRST;
                    end else begin
                        phase_next = gcsd_pkg::PH_PARAMS;
                    end
                end
                gcsd_pkg::PH_PARAMS: begin
                    res_valid = 1'b1;
                    npi_next  = npi_reg + 1'b1;
                    // The next command must begin on an even offset.
                    if (({1'b0, npi_reg} + 1'b1) == total_reg) begin
                        phase_next = pos[0] ? gcsd_pkg::PH_FIRST : gcsd_pkg::PH_PAD;
                    end
                end
                default: begin
                    phase_next = gcsd_pkg::PH_FIRST;
                end
            endcase
        end
    end

    // Results use the command fields as they stand after this word.
    assign e_last    = ({1'b0, e_idx} + 1'b1) == total_next;
    assign e_idx_top = e_idx | gcsd_pkg::IDX_W'(3);
    assign is_entry  = cmd_next == gcsd_pkg::CMD_ENTRY_LIST;
    assign cs_ext    = {{gcsd_pkg::OFS_W{1'b0}}, cs_reg};

    always_comb begin
        res.command_id       = cmd_next;
        res.param_index      = e_idx;
        res.param_value      = e_val;
        res.last_param       = e_last;
        res.command_offset   = cs_ext[gcsd_pkg::OFS_W-1:0];
        res.vertex_list_mode = mode_next;
        res.entry_index      = is_entry ? e_idx[gcsd_pkg::IDX_W-1:2] : '0;
        res.entry_lane       = is_entry ? e_idx[1:0] : '0;
        res.entry_incomplete = is_entry && ({1'b0, e_idx_top} >= total_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= gcsd_pkg::PH_FIRST;
            held_reg  <= '0;
            cmd_reg   <= '0;
            total_reg <= '0;
            npi_reg   <= '0;
            wc_reg    <= '0;
            cs_reg    <= '0;
            mode_reg  <= '0;
        end else begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
            cmd_reg   <= cmd_next;
            total_reg <= total_next;
            npi_reg   <= npi_next;
            wc_reg    <= wc_next;
            cs_reg    <= cs_next;
            mode_reg  <= mode_next;
        end
    end

endmodule

// File: hw/rtl/gcsd_out_stage.sv
// Result register of the deframer: holds one result until the downstream
// side takes it. Depends on gcsd_pkg.
`timescale 1ns / 1ps

module gcsd_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              fire,
    input  logic              res_valid,
    input  gcsd_pkg::result_t res,
    output logic              pipe_ready,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output gcsd_pkg::result_t m_res
);

    logic              valid_reg;
    logic              valid_next;
    gcsd_pkg::result_t res_reg;

    assign pipe_ready    = !valid_reg || m_axis_tready;
    assign m_axis_tvalid = valid_reg;
    assign m_res         = res_reg;

    // A pad or first-parameter word clears the register if its result was taken; so does a take with no word.
    always_comb begin
        valid_next = valid_reg;
        if (fire) begin
            valid_next = res_valid;
        end else if (m_axis_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && res_valid) begin
            res_reg <= res;
        end
    end

endmodule

// File: hw/rtl/gpu_command_stream_deframer_core.sv
// Top level of the GPU command stream deframer: input register, parser and
// result register. Depends on gcsd_pkg, gcsd_in_stage, gcsd_parser, gcsd_out_stage.
//
//   Channel  Ports        Contents
//   input    s_axis_*     tdata: word[31:0]; tuser: buffer_start
//   result   m_axis_*     tdata: parameter result fields; tlast: last_param
//
// One word per cycle is accepted while the result side does not stall; each word passes
// from the input register through the parser, and any result is offered from the result register.
// The parse state takes a single update for each word that is fired.
// Reset is synchronous and active low; it clears parse state and both valids.
// A stalled result holds the pipeline; the input register still fills once.
`timescale 1ns / 1ps

module gpu_command_stream_deframer_core #(
    parameter int OFFSET_BITS = gcsd_pkg::OFFSET_BITS_DEFAULT
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,   // word[31:0]
    input  logic [0:0]   s_axis_tuser,   // buffer_start[0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // command_id[19:0], param_index[30:20], param_value[62:31],
    // command_offset[82:63], vertex_list_mode[114:83], entry_index[123:115],
    // entry_lane[125:124], entry_incomplete[126], zero[127]
    output logic [127:0] m_axis_tdata,
    output logic         m_axis_tlast    // last_param
);

    gcsd_pkg::in_item_t s_item;
    gcsd_pkg::in_item_t item;
    gcsd_pkg::result_t  res;
    gcsd_pkg::result_t  m_res;
    logic               fire;
    logic               pipe_ready;
    logic               res_valid;

    assign s_item.word         = s_axis_tdata;
    assign s_item.buffer_start = s_axis_tuser[0];

    gcsd_in_stage u_in (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_item        (s_item),
        .pipe_ready    (pipe_ready),
        .fire          (fire),
        .item          (item)
    );

    gcsd_parser #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    gcsd_out_stage u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .fire          (fire),
        .res_valid     (res_valid),
        .res           (res),
        .pipe_ready    (pipe_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_res         (m_res)
    );

    assign m_axis_tdata = {1'b0,
                           m_res.entry_incomplete,
                           m_res.entry_lane,
                           m_res.entry_index,
                           m_res.vertex_list_mode,
                           m_res.command_offset,
                           m_res.param_value,
                           m_res.param_index,
                           m_res.command_id};
    assign m_axis_tlast = m_res.last_param;

endmodule
